// File: rtl/i2csrp_pkg.sv
package i2csrp_pkg;

    localparam int TX_DEPTH_DEF = 256;
    localparam int RX_DEPTH_DEF = 128;

    localparam logic [7:0] PTR_CHANNEL  = 8'd10;
    localparam logic [7:0] PTR_MODE     = 8'd11;
    localparam logic [7:0] PTR_COUPLING = 8'd12;
    localparam logic [7:0] CHANNEL_MAX  = 8'd8;

    localparam logic [7:0] TX_LAST_RST    = 8'd114;
    localparam logic [7:0] MODE_LIMIT_RST = 8'd15;
    localparam logic [7:0] DC_CODE_RST    = 8'd0;
    localparam logic [7:0] AC_CODE_RST    = 8'd1;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_TX_LAST    = 2'd0,
        REG_MODE_LIMIT = 2'd1,
        REG_DC_CODE    = 2'd2,
        REG_AC_CODE    = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        CMD_WR_ADDR = 3'd0,
        CMD_RX_BYTE = 3'd1,
        CMD_RD_ADDR = 3'd2,
        CMD_TX_BYTE = 3'd3,
        CMD_STOP    = 3'd4,
        CMD_HOST_LD = 3'd5,
        CMD_HOST_RD = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_WR_ADDR = 3'd1,
        PH_POINTER = 3'd2,
        PH_WR_DATA = 3'd3,
        PH_RD_ADDR = 3'd4,
        PH_RD_DATA = 3'd5
    } t_phase;

    typedef struct packed {
        logic       tx_valid;
        logic       rx_sel;
        logic       channel_set;
        logic [3:0] channel_value;
        logic       mode_set;
        logic [7:0] mode_value;
        logic       coupling_set;
        logic       coupling_ac;
        t_phase     link_phase;
    } t_res_ctl;

endpackage

// File: rtl/i2csrp_if.sv
interface i2csrp_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] data_byte;
    logic [7:0] host_index;

    modport source (output valid, output command, output data_byte, output host_index,
                    input ready);
    modport sink (input valid, input command, input data_byte, input host_index,
                  output ready);
endinterface

interface i2csrp_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       channel_set;
    logic [3:0] channel_value;
    logic       mode_set;
    logic [7:0] mode_value;
    logic       coupling_set;
    logic       coupling_ac;
    logic [7:0] rx_byte;
    logic [2:0] link_phase;

    modport source (output valid, output tx_byte, output tx_valid, output channel_set,
                    output channel_value, output mode_set, output mode_value,
                    output coupling_set, output coupling_ac, output rx_byte,
                    output link_phase, input ready);
    modport sink (input valid, input tx_byte, input tx_valid, input channel_set,
                  input channel_value, input mode_set, input mode_value,
                  input coupling_set, input coupling_ac, input rx_byte,
                  input link_phase, output ready);
endinterface

// File: rtl/i2csrp_buf.sv
module i2csrp_buf #(
    parameter int DEPTH = i2csrp_pkg::TX_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]       r_q;
    logic             r_qv;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_qv <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_qv ? r_q : 8'd0;

endmodule

// File: rtl/i2c_slave_register_port_top.sv
// Channel   Direction  Handshake       Contents
// i_req     in         valid/ready     command, data_byte, host_index
// o_res     out        valid/ready     tx/rx bytes, decoded settings, link_phase
// APB       in         psel/penable    tx_last_index, mode_limit, dc_code, ac_code
//
// One request per cycle while no stalled result is pending; each result appears in the cycle after its request.
// The buffer read port is registered, and the result register holds that cycle.
// Reset is synchronous; buffers read as zero until written, with no clearing pass.
// A stalled result blocks new requests only while it is not taken.
module i2c_slave_register_port_top #(
    parameter int TX_DEPTH = i2csrp_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = i2csrp_pkg::RX_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    i2csrp_req_if.sink                       i_req,
    i2csrp_res_if.source                     o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2csrp_pkg::PADDR_W-1:0]   paddr,
    input  logic [i2csrp_pkg::PDATA_W-1:0]   pwdata,
    output logic [i2csrp_pkg::PDATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int TAW = $clog2(TX_DEPTH);
    localparam int RAW = $clog2(RX_DEPTH);

    logic [7:0] r_tx_last;
    logic [7:0] r_mode_limit;
    logic [7:0] r_dc_code;
    logic [7:0] r_ac_code;

    i2csrp_pkg::t_phase r_phase;
    i2csrp_pkg::t_phase n_phase;
    logic [7:0]         r_ptr;
    logic [7:0]         n_ptr;
    logic [RAW-1:0]     r_rx_pos;
    logic [RAW-1:0]     n_rx_pos;
    logic [TAW-1:0]     r_tx_pos;
    logic [TAW-1:0]     n_tx_pos;

    logic                 r_out_vld;
    i2csrp_pkg::t_res_ctl r_ctl;
    i2csrp_pkg::t_res_ctl n_ctl;

    logic               acc;
    i2csrp_pkg::t_cmd   cmd;
    logic [7:0]         data;
    logic               tx_we;
    logic               tx_re;
    logic [TAW-1:0]     tx_raddr;
    logic               rx_we;
    logic               rx_re;
    logic [8:0]         tx_stop;
    logic [TAW-1:0]     tx_base;
    logic [7:0]         tx_rdata;
    logic [7:0]         rx_rdata;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_last    <= i2csrp_pkg::TX_LAST_RST;
            r_mode_limit <= i2csrp_pkg::MODE_LIMIT_RST;
            r_dc_code    <= i2csrp_pkg::DC_CODE_RST;
            r_ac_code    <= i2csrp_pkg::AC_CODE_RST;
        end else if (cfg_wr) begin
            unique case (i2csrp_pkg::t_reg'(paddr[3:2]))
                i2csrp_pkg::REG_TX_LAST:    r_tx_last    <= pwdata[7:0];
                i2csrp_pkg::REG_MODE_LIMIT: r_mode_limit <= pwdata[7:0];
                i2csrp_pkg::REG_DC_CODE:    r_dc_code    <= pwdata[7:0];
                i2csrp_pkg::REG_AC_CODE:    r_ac_code    <= pwdata[7:0];
                default:                    r_tx_last    <= r_tx_last;
            endcase
        end
    end

    always_comb begin
        unique case (i2csrp_pkg::t_reg'(paddr[3:2]))
            i2csrp_pkg::REG_TX_LAST:    prdata = {24'd0, r_tx_last};
            i2csrp_pkg::REG_MODE_LIMIT: prdata = {24'd0, r_mode_limit};
            i2csrp_pkg::REG_DC_CODE:    prdata = {24'd0, r_dc_code};
            i2csrp_pkg::REG_AC_CODE:    prdata = {24'd0, r_ac_code};
            default:                    prdata = '0;
        endcase
    end

    assign i_req.ready = !r_out_vld || o_res.ready;
    assign acc         = i_req.valid && i_req.ready;
    assign cmd         = i2csrp_pkg::t_cmd'(i_req.command);
    assign data        = i_req.data_byte;

    assign tx_stop = ({1'b0, r_tx_last} < 9'(TX_DEPTH - 1)) ? {1'b0, r_tx_last}
                                                           : 9'(TX_DEPTH - 1);
    assign tx_base = (cmd == i2csrp_pkg::CMD_RD_ADDR) ? '0 : r_tx_pos;

    always_comb begin
        n_phase  = r_phase;
        n_ptr    = r_ptr;
        n_rx_pos = r_rx_pos;
        n_tx_pos = r_tx_pos;
        tx_we    = 1'b0;
        tx_re    = 1'b0;
        tx_raddr = tx_base;
        rx_we    = 1'b0;
        rx_re    = 1'b0;
        n_ctl    = '0;
        unique case (cmd)
            i2csrp_pkg::CMD_WR_ADDR: begin
                n_phase = i2csrp_pkg::PH_WR_ADDR;
            end
            i2csrp_pkg::CMD_RX_BYTE: begin
                if (r_phase == i2csrp_pkg::PH_WR_ADDR) begin
                    n_phase  = i2csrp_pkg::PH_POINTER;
                    n_ptr    = data;
                    n_rx_pos = '0;
                end else begin
                    n_phase = i2csrp_pkg::PH_WR_DATA;
                    rx_we   = 1'b1;
                    if (r_rx_pos < RAW'(RX_DEPTH - 1)) begin
                        n_rx_pos = r_rx_pos + 1'b1;
                    end
                    if (r_ptr == i2csrp_pkg::PTR_CHANNEL && data != 8'd0 &&
                        data <= i2csrp_pkg::CHANNEL_MAX) begin
                        n_ctl.channel_set   = 1'b1;
                        n_ctl.channel_value = data[3:0];
                    end
                    if (r_ptr == i2csrp_pkg::PTR_MODE && data <= r_mode_limit) begin
                        n_ctl.mode_set   = 1'b1;
                        n_ctl.mode_value = data;
                    end
                    if (r_ptr == i2csrp_pkg::PTR_COUPLING) begin
                        if (data == r_dc_code) begin
                            n_ctl.coupling_set = 1'b1;
                        end else if (data == r_ac_code) begin
                            n_ctl.coupling_set = 1'b1;
                            n_ctl.coupling_ac  = 1'b1;
                        end
                    end
                end
            end
            i2csrp_pkg::CMD_RD_ADDR, i2csrp_pkg::CMD_TX_BYTE: begin
                n_phase = (cmd == i2csrp_pkg::CMD_RD_ADDR) ? i2csrp_pkg::PH_RD_ADDR
                                                           : i2csrp_pkg::PH_RD_DATA;
                tx_re          = 1'b1;
                n_ctl.tx_valid = 1'b1;
                n_tx_pos       = tx_base;
                if (9'(tx_base) < tx_stop) begin
                    n_tx_pos = tx_base + 1'b1;
                end
            end
            i2csrp_pkg::CMD_STOP: begin
                n_phase = i2csrp_pkg::PH_IDLE;
            end
            i2csrp_pkg::CMD_HOST_LD: begin
                tx_we = ({1'b0, i_req.host_index} < 9'(TX_DEPTH));
            end
            i2csrp_pkg::CMD_HOST_RD: begin
                rx_re        = ({1'b0, i_req.host_index} < 9'(RX_DEPTH));
                n_ctl.rx_sel = rx_re;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        n_ctl.link_phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= i2csrp_pkg::PH_IDLE;
            r_ptr     <= '0;
            r_rx_pos  <= '0;
            r_tx_pos  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (acc) begin
                r_phase  <= n_phase;
                r_ptr    <= n_ptr;
                r_rx_pos <= n_rx_pos;
                r_tx_pos <= n_tx_pos;
            end
            if (acc) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ctl <= n_ctl;
        end
    end

    i2csrp_buf #(
        .DEPTH (TX_DEPTH)
    ) u_tx_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (acc && tx_we),
        .i_waddr (i_req.host_index[TAW-1:0]),
        .i_wdata (data),
        .i_re    (acc && tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    i2csrp_buf #(
        .DEPTH (RX_DEPTH)
    ) u_rx_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (acc && rx_we),
        .i_waddr (r_rx_pos),
        .i_wdata (data),
        .i_re    (acc && rx_re),
        .i_raddr (i_req.host_index[RAW-1:0]),
        .o_rdata (rx_rdata)
    );

    assign o_res.valid         = r_out_vld;
    assign o_res.tx_byte       = r_ctl.tx_valid ? tx_rdata : 8'd0;
    assign o_res.tx_valid      = r_ctl.tx_valid;
    assign o_res.channel_set   = r_ctl.channel_set;
    assign o_res.channel_value = r_ctl.channel_value;
    assign o_res.mode_set      = r_ctl.mode_set;
    assign o_res.mode_value    = r_ctl.mode_value;
    assign o_res.coupling_set  = r_ctl.coupling_set;
    assign o_res.coupling_ac   = r_ctl.coupling_ac;
    assign o_res.rx_byte       = r_ctl.rx_sel ? rx_rdata : 8'd0;
    assign o_res.link_phase    = r_ctl.link_phase;

endmodule

// File: rtl/i2csrp_chk.sv
module i2csrp_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_tx_valid,
    input logic       i_channel_set,
    input logic [3:0] i_channel_value,
    input logic       i_mode_set,
    input logic       i_coupling_set,
    input logic [2:0] i_link_phase
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid right after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Stalled result dropped.");

    a_tx_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_tx_valid |->
            i_link_phase == i2csrp_pkg::PH_RD_ADDR || i_link_phase == i2csrp_pkg::PH_RD_DATA)
        else $error("Transmit byte outside a read phase.");

    a_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_channel_set |->
            i_link_phase == i2csrp_pkg::PH_WR_DATA && i_channel_value != 4'd0 &&
            i_channel_value <= i2csrp_pkg::CHANNEL_MAX[3:0])
        else $error("Channel selection out of range or outside write data.");

    a_one_setting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $countones({i_channel_set, i_mode_set, i_coupling_set}) <= 1)
        else $error("More than one setting decoded from one byte.");

endmodule

bind i2c_slave_register_port_top i2csrp_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_tx_valid      (o_res.tx_valid),
    .i_channel_set   (o_res.channel_set),
    .i_channel_value (o_res.channel_value),
    .i_mode_set      (o_res.mode_set),
    .i_coupling_set  (o_res.coupling_set),
    .i_link_phase    (o_res.link_phase)
);

// File: tb/i2csrp_checker.sv
module i2csrp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    i2csrp_req_if                          i_req,
    i2csrp_res_if                          i_res,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [i2csrp_pkg::PADDR_W-1:0] i_paddr,
    input  logic [i2csrp_pkg::PDATA_W-1:0] i_pwdata,
    input  logic                           i_pready,
    output int                             o_error_count,
    output int                             o_pending
);
    import i2csrp_pkg::*;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       channel_set;
        logic [3:0] channel_value;
        logic       mode_set;
        logic [7:0] mode_value;
        logic       coupling_set;
        logic       coupling_ac;
        logic [7:0] rx_byte;
        logic [2:0] link_phase;
    } t_bus_result;

    t_bus_result expected_results[$];

    logic [7:0] cfg_tx_last;
    logic [7:0] cfg_mode_limit;
    logic [7:0] cfg_dc;
    logic [7:0] cfg_ac;

    t_phase     link_state;
    logic [7:0] reg_ptr;
    logic [6:0] rx_pos;
    logic [7:0] tx_pos;
    logic [7:0] tx_mem [TX_DEPTH_DEF];
    logic [7:0] rx_mem [RX_DEPTH_DEF];
    int         result_index;

    initial begin
        for (int i = 0; i < TX_DEPTH_DEF; i++) tx_mem[i] = 8'd0;
        for (int i = 0; i < RX_DEPTH_DEF; i++) rx_mem[i] = 8'd0;
        cfg_tx_last    = TX_LAST_RST;
        cfg_mode_limit = MODE_LIMIT_RST;
        cfg_dc         = DC_CODE_RST;
        cfg_ac         = AC_CODE_RST;
        link_state     = PH_IDLE;
        reg_ptr        = 8'd0;
        rx_pos         = 7'd0;
        tx_pos         = 8'd0;
        result_index   = 0;
        o_error_count  = 0;
        o_pending      = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] result %0d: %s", $realtime, result_index, what);
        o_error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    task automatic send_tx_entry(inout t_bus_result r);
        r.tx_byte  = tx_mem[tx_pos];
        r.tx_valid = 1'b1;
        if (tx_pos < cfg_tx_last && tx_pos < TX_DEPTH_DEF - 1) begin
            tx_pos++;
        end
    endtask

    task automatic predict_link_event(input logic [2:0] cmd, input logic [7:0] data,
                                      input logic [7:0] idx);
        t_bus_result r;
        r = '0;
        case (cmd)
            CMD_WR_ADDR: link_state = PH_WR_ADDR;
            CMD_RX_BYTE: begin
                if (link_state == PH_WR_ADDR) begin
                    link_state = PH_POINTER;
                    reg_ptr    = data;
                    rx_pos     = 7'd0;
                end else begin
                    link_state     = PH_WR_DATA;
                    rx_mem[rx_pos] = data;
                    if (rx_pos < RX_DEPTH_DEF - 1) begin
                        rx_pos++;
                    end
                    if (reg_ptr == PTR_CHANNEL && data >= 8'd1 && data <= CHANNEL_MAX) begin
                        r.channel_set   = 1'b1;
                        r.channel_value = data[3:0];
                    end
                    if (reg_ptr == PTR_MODE && data <= cfg_mode_limit) begin
                        r.mode_set   = 1'b1;
                        r.mode_value = data;
                    end
                    if (reg_ptr == PTR_COUPLING) begin
                        if (data == cfg_dc) begin
                            r.coupling_set = 1'b1;
                        end else if (data == cfg_ac) begin
                            r.coupling_set = 1'b1;
                            r.coupling_ac  = 1'b1;
                        end
                    end
                end
            end
            CMD_RD_ADDR: begin
                link_state = PH_RD_ADDR;
                tx_pos     = 8'd0;
                send_tx_entry(r);
            end
            CMD_TX_BYTE: begin
                link_state = PH_RD_DATA;
                send_tx_entry(r);
            end
            CMD_STOP: link_state = PH_IDLE;
            CMD_HOST_LD: begin
                if (idx < TX_DEPTH_DEF) begin
                    tx_mem[idx] = data;
                end
            end
            CMD_HOST_RD: begin
                if (idx < RX_DEPTH_DEF) begin
                    r.rx_byte = rx_mem[idx];
                end
            end
            default: ;
        endcase
        r.link_phase = link_state;
        expected_results.push_back(r);
    endtask

    task automatic check_result();
        t_bus_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result arrived with no request outstanding");
        end else begin
            want = expected_results.pop_front();
            check_field("tx_byte", i_res.tx_byte, want.tx_byte);
            check_field("tx_valid", 8'(i_res.tx_valid), 8'(want.tx_valid));
            check_field("channel_set", 8'(i_res.channel_set), 8'(want.channel_set));
            check_field("channel_value", 8'(i_res.channel_value), 8'(want.channel_value));
            check_field("mode_set", 8'(i_res.mode_set), 8'(want.mode_set));
            check_field("mode_value", i_res.mode_value, want.mode_value);
            check_field("coupling_set", 8'(i_res.coupling_set), 8'(want.coupling_set));
            check_field("coupling_ac", 8'(i_res.coupling_ac), 8'(want.coupling_ac));
            check_field("rx_byte", i_res.rx_byte, want.rx_byte);
            check_field("link_phase", 8'(i_res.link_phase), 8'(want.link_phase));
        end
        result_index++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_res.valid && i_res.ready) begin
                check_result();
            end
            if (i_req.valid && i_req.ready) begin
                predict_link_event(i_req.command, i_req.data_byte, i_req.host_index);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg'(i_paddr[3:2]))
                    REG_TX_LAST:    cfg_tx_last    = i_pwdata[7:0];
                    REG_MODE_LIMIT: cfg_mode_limit = i_pwdata[7:0];
                    REG_DC_CODE:    cfg_dc         = i_pwdata[7:0];
                    default:        cfg_ac         = i_pwdata[7:0];
                endcase
            end
            o_pending = expected_results.size();
        end
    end
endmodule

// File: tb/tb_i2c_slave_register_port_top.sv
module tb_i2c_slave_register_port_top;
    import i2csrp_pkg::*;

    localparam int         CLK_HALF           = 4;
    localparam int         TIMEOUT_CYCLES     = 400_000;
    localparam int         DRAIN_LIMIT        = 5_000;
    localparam int         SETTING_COUNT      = 5;
    localparam int         RANDOM_PER_SETTING = 290;
    localparam logic [2:0] CMD_UNUSED         = 3'd7;

    typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_LONG} t_stall_style;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 error_count;
    int                 pending_count;
    int                 burst_left;
    int                 sent_items;
    logic [7:0]         cur_mode_limit;
    logic [7:0]         cur_dc;
    logic [7:0]         cur_ac;
    logic [7:0]         cur_tx_last;

    i2csrp_req_if req_ch();
    i2csrp_res_if res_ch();

    i2c_slave_register_port_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    i2csrp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_error_count (error_count),
        .o_pending     (pending_count)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : receiver_stalls
        t_stall_style style;
        int           style_left;
        int           hold_left;
        int           tick;
        res_ch.ready = 1'b1;
        style        = STALL_NONE;
        style_left   = 0;
        hold_left    = 0;
        tick         = 0;
        forever begin
            @(negedge i_clk);
            if (style_left == 0) begin
                style      = t_stall_style'($urandom_range(0, 3));
                style_left = $urandom_range(16, 120);
            end
            style_left--;
            tick++;
            case (style)
                STALL_NONE:     res_ch.ready <= 1'b1;
                STALL_COIN:     res_ch.ready <= 1'($urandom_range(0, 1));
                STALL_PERIODIC: res_ch.ready <= (tick % 4) != 0;
                default: begin
                    if (hold_left == 0) begin
                        hold_left = $urandom_range(1, 6);
                        res_ch.ready <= 1'b1;
                    end else begin
                        hold_left--;
                        res_ch.ready <= 1'b0;
                    end
                end
            endcase
        end
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] buffer_index();
        return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : any_byte();
    endfunction

    function automatic logic [7:0] register_data(input logic [7:0] pointer);
        case ($urandom_range(0, 3))
            0:       return any_byte();
            1:       return (pointer == PTR_MODE) ? cur_mode_limit : cur_dc;
            2:       return (pointer == PTR_MODE) ? cur_mode_limit + 8'd1 : cur_ac;
            default: return 8'($urandom_range(0, 9));
        endcase
    endfunction

    task automatic send_request(input logic [2:0] cmd, input logic [7:0] data,
                                input logic [7:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.data_byte  <= data;
        req_ch.host_index <= idx;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        sent_items++;
    endtask

    task automatic settle_requests();
        int waited;
        req_ch.valid <= 1'b0;
        burst_left = 0;
        waited = 0;
        while (pending_count != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input t_reg which, input logic [7:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {which, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input int setting);
        case (setting)
            0: begin
                cur_tx_last = 8'd0;   cur_mode_limit = 8'd0;   cur_dc = 8'd255; cur_ac = 8'd0;
            end
            1: begin
                cur_tx_last = 8'd255; cur_mode_limit = 8'd255; cur_dc = 8'd7;   cur_ac = 8'd7;
            end
            2: begin
                cur_tx_last = 8'd3;   cur_mode_limit = 8'd8;   cur_dc = 8'd1;   cur_ac = 8'd2;
            end
            default: begin
                cur_tx_last    = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 20))
                                                             : any_byte();
                cur_mode_limit = any_byte();
                cur_dc         = any_byte();
                cur_ac         = any_byte();
            end
        endcase
        write_register(REG_TX_LAST, cur_tx_last);
        write_register(REG_MODE_LIMIT, cur_mode_limit);
        write_register(REG_DC_CODE, cur_dc);
        write_register(REG_AC_CODE, cur_ac);
    endtask

    task automatic run_write_transfer();
        logic [7:0] pointer;
        int         count;
        send_request(CMD_WR_ADDR, any_byte(), any_byte());
        case ($urandom_range(0, 3))
            0:       pointer = PTR_CHANNEL;
            1:       pointer = PTR_MODE;
            2:       pointer = PTR_COUPLING;
            default: pointer = any_byte();
        endcase
        send_request(CMD_RX_BYTE, pointer, any_byte());
        count = ($urandom_range(0, 11) == 0) ? $urandom_range(125, 140) : $urandom_range(0, 6);
        repeat (count) send_request(CMD_RX_BYTE, register_data(pointer), any_byte());
        if ($urandom_range(0, 7) != 0) begin
            send_request(CMD_STOP, any_byte(), any_byte());
        end
    endtask

    task automatic run_read_transfer();
        int count;
        send_request(CMD_RD_ADDR, any_byte(), any_byte());
        count = ($urandom_range(0, 11) == 0) ? $urandom_range(120, 265) : $urandom_range(0, 8);
        repeat (count) send_request(CMD_TX_BYTE, any_byte(), any_byte());
        if ($urandom_range(0, 7) != 0) begin
            send_request(CMD_STOP, any_byte(), any_byte());
        end
    endtask

    task automatic run_random_traffic(input int target);
        int goal;
        goal = sent_items + target;
        while (sent_items < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: run_write_transfer();
                4, 5:       run_read_transfer();
                6: repeat ($urandom_range(1, 4))
                       send_request(CMD_HOST_LD, any_byte(), buffer_index());
                7: repeat ($urandom_range(1, 4))
                       send_request(CMD_HOST_RD, any_byte(), buffer_index());
                8: repeat ($urandom_range(1, 3))
                       send_request(3'($urandom_range(0, 7)), any_byte(), any_byte());
                default: begin
                    send_request(CMD_WR_ADDR, any_byte(), any_byte());
                    send_request(($urandom_range(0, 1) == 0) ? CMD_STOP : CMD_RD_ADDR,
                                 any_byte(), any_byte());
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_STOP;
        req_ch.data_byte  = 8'd0;
        req_ch.host_index = 8'd0;
        burst_left        = 0;
        sent_items        = 0;
        cur_tx_last       = TX_LAST_RST;
        cur_mode_limit    = MODE_LIMIT_RST;
        cur_dc            = DC_CODE_RST;
        cur_ac            = AC_CODE_RST;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(CMD_HOST_LD, 8'hA5, 8'd0);
        send_request(CMD_HOST_LD, 8'hFF, 8'd255);
        send_request(CMD_RX_BYTE, 8'h33, 8'd0);
        send_request(CMD_WR_ADDR, 8'd0, 8'd0);
        send_request(CMD_RX_BYTE, PTR_CHANNEL, 8'd0);
        send_request(CMD_RX_BYTE, 8'd0, 8'd0);
        send_request(CMD_RX_BYTE, 8'd1, 8'd0);
        send_request(CMD_RX_BYTE, CHANNEL_MAX, 8'd0);
        send_request(CMD_RX_BYTE, 8'd9, 8'd0);
        send_request(CMD_WR_ADDR, 8'd0, 8'd0);
        send_request(CMD_RX_BYTE, PTR_MODE, 8'd0);
        send_request(CMD_RX_BYTE, MODE_LIMIT_RST, 8'd0);
        send_request(CMD_RX_BYTE, 8'd255, 8'd0);
        send_request(CMD_WR_ADDR, 8'd0, 8'd0);
        send_request(CMD_RX_BYTE, PTR_COUPLING, 8'd0);
        send_request(CMD_RX_BYTE, DC_CODE_RST, 8'd0);
        send_request(CMD_RX_BYTE, AC_CODE_RST, 8'd0);
        send_request(CMD_RX_BYTE, 8'd2, 8'd0);
        send_request(CMD_STOP, 8'd0, 8'd0);
        send_request(CMD_RD_ADDR, 8'd0, 8'd0);
        send_request(CMD_TX_BYTE, 8'd0, 8'd0);
        send_request(CMD_HOST_RD, 8'd0, 8'd0);
        send_request(CMD_HOST_RD, 8'd0, 8'd127);
        send_request(CMD_HOST_RD, 8'd0, 8'd128);
        send_request(CMD_UNUSED, 8'd255, 8'd255);

        for (int setting = 0; setting < SETTING_COUNT; setting++) begin
            settle_requests();
            apply_setting(setting);
            run_random_traffic(RANDOM_PER_SETTING);
        end
        settle_requests();

        if (error_count == 0 && pending_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
